[rtl/scx_pkg.sv]
// Package: shared types, constants and functions for the Salsa20/ChaCha20 stream XOR core.
package scx_pkg;

	localparam int LANE_BYTES = 8;
	localparam int DOUBLE_ROUNDS = 10;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam logic [2:0] REG_CIPHER = 3'd0;
	localparam logic [2:0] REG_KEY0 = 3'd1;
	localparam logic [2:0] REG_KEY1 = 3'd2;
	localparam logic [2:0] REG_KEY2 = 3'd3;
	localparam logic [2:0] REG_KEY3 = 3'd4;
	localparam logic [2:0] REG_NONCE_LO = 3'd5;
	localparam logic [2:0] REG_NONCE_HI = 3'd6;
	localparam logic [2:0] REG_START = 3'd7;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;

	// request held between front and back
	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        last;
	} req_t;

	// back-end state machine
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_XOR
	} back_state_t;

	function automatic word_t rotl(input word_t v, input int unsigned n);
		word_t r;
		r = (v << n) | (v >> (32 - n));
		return r;
	endfunction

	function automatic block_t salsa_qr(input block_t x, input int a, input int b,
		input int c, input int d);
		block_t y;
		y = x;
		y[b] = y[b] ^ rotl(y[a] + y[d], 7);
		y[c] = y[c] ^ rotl(y[b] + y[a], 9);
		y[d] = y[d] ^ rotl(y[c] + y[b], 13);
		y[a] = y[a] ^ rotl(y[d] + y[c], 18);
		return y;
	endfunction

	function automatic block_t chacha_qr(input block_t x, input int a, input int b,
		input int c, input int d);
		block_t y;
		y = x;
		y[a] = y[a] + y[b]; y[d] = rotl(y[d] ^ y[a], 16);
		y[c] = y[c] + y[d]; y[b] = rotl(y[b] ^ y[c], 12);
		y[a] = y[a] + y[b]; y[d] = rotl(y[d] ^ y[a], 8);
		y[c] = y[c] + y[d]; y[b] = rotl(y[b] ^ y[c], 7);
		return y;
	endfunction

	// one full double round
	function automatic block_t double_round(input block_t x, input logic salsa);
		block_t w;
		w = x;
		if (salsa) begin
			w = salsa_qr(w, 0, 4, 8, 12);
			w = salsa_qr(w, 5, 9, 13, 1);
			w = salsa_qr(w, 10, 14, 2, 6);
			w = salsa_qr(w, 15, 3, 7, 11);
			w = salsa_qr(w, 0, 1, 2, 3);
			w = salsa_qr(w, 5, 6, 7, 4);
			w = salsa_qr(w, 10, 11, 8, 9);
			w = salsa_qr(w, 15, 12, 13, 14);
		end else begin
			w = chacha_qr(w, 0, 4, 8, 12);
			w = chacha_qr(w, 1, 5, 9, 13);
			w = chacha_qr(w, 2, 6, 10, 14);
			w = chacha_qr(w, 3, 7, 11, 15);
			w = chacha_qr(w, 0, 5, 10, 15);
			w = chacha_qr(w, 1, 6, 11, 12);
			w = chacha_qr(w, 2, 7, 8, 13);
			w = chacha_qr(w, 3, 4, 9, 14);
		end
		return w;
	endfunction

endpackage

[rtl/salsa_chacha_stream_xor_core.sv]
// Top level: Salsa20/ChaCha20 stream XOR core, front queue plus keystream back end.
// channel | signals                                   | accepted when
// input   | in_valid/in_stall, data_in, byte_count, last_item | in_valid && !in_stall
// output  | out_valid/out_stall, data_out, valid_bytes, last_out | out_valid && !out_stall
// config  | cfg_we, cfg_idx, cfg_data                 | cfg_we
// An item whose bytes lie in a held keystream block is XORed in the back end without a new block.
// A new 64-byte block is built in steps: load, 10 double rounds on the one double-round
// unit, feed-forward add; a request crossing a block edge takes two passes.
// Reset sets Salsa20, zero key, nonce and counter, no block held.
// A two-entry queue and the output register let either side stall independently.
`default_nettype none
module salsa_chacha_stream_xor_core import scx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_in,
	input  wire logic [3:0]  byte_count,
	input  wire logic        last_item,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      data_out,
	output logic [3:0]       valid_bytes,
	output logic             last_out
);

	logic q_valid, q_pop;
	req_t q_head;

	scx_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .data_in, .byte_count, .last_item,
		.q_valid, .q_pop, .q_head
	);

	scx_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data, .q_valid, .q_pop, .q_head,
		.out_valid, .out_stall, .data_out, .valid_bytes, .last_out
	);

endmodule
`default_nettype wire

[rtl/scx_front.sv]
// Front end: accepts input requests, clamps the byte count and queues them for the back end.
`default_nettype none
module scx_front import scx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] data_in,
	input  wire logic [3:0]  byte_count,
	input  wire logic        last_item,
	output logic             q_valid,
	input  wire logic        q_pop,
	output req_t             q_head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	req_t            mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   rd_q, wr_q;
	logic [PW:0]     cnt_q;
	logic            push;
	req_t            req;

	assign in_stall = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_head = mem_q[rd_q];

	always_comb begin
		req.data = data_in;
		req.count = (byte_count > 4'(LANE_BYTES)) ? 4'(LANE_BYTES) : byte_count;
		req.last = last_item;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

endmodule
`default_nettype wire

[rtl/scx_back.sv]
// Back end: keystream generation with an iterative double-round core and the XOR of one request.
`default_nettype none
module scx_back import scx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	input  wire logic        q_valid,
	output logic             q_pop,
	input  req_t             q_head,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      data_out,
	output logic [3:0]       valid_bytes,
	output logic             last_out
);

	logic        salsa_q;
	logic [63:0] key_q [4];
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;
	logic [63:0] start_q;
	logic [63:0] ctr_q;
	logic [5:0]  pos_q;
	logic        ready_q;
	block_t      init_q, work_q, ks_q;
	logic [3:0]  rnd_q;
	back_state_t st_q, st_d;

	logic        ovalid_q;
	logic [63:0] odata_q;
	logic [3:0]  ocnt_q;
	logic        olast_q;

	// position in the held block after the bytes of this request
	logic [6:0]  end_pos;
	logic        out_free;
	logic        need_block;
	logic        do_xor;
	logic [63:0] xres;
	logic [6:0]  p;
	logic [5:0]  new_pos;
	logic        wrap;
	logic [3:0]  done_cnt;
	logic [63:0] acc_q;
	logic [3:0]  base_q;
	logic [511:0] ks_flat;
	block_t      init_d;
	block_t      dr;

	assign out_free = !ovalid_q || !out_stall;
	assign out_valid = ovalid_q;
	assign data_out = odata_q;
	assign valid_bytes = ocnt_q;
	assign last_out = olast_q;

	always_comb begin
		for (int i = 0; i < 16; i++) ks_flat[32*i +: 32] = ks_q[i];
	end

	// bytes still to do in this request, starting at base_q
	always_comb begin
		logic [3:0] rem;
		logic [6:0] avail;
		rem = q_head.count - base_q;
		avail = 7'd64 - {1'b0, pos_q};
		done_cnt = (7'(rem) <= avail) ? rem : avail[3:0];
		end_pos = {1'b0, pos_q} + 7'(done_cnt);
		wrap = (end_pos == 7'd64);
		new_pos = end_pos[5:0];
		xres = acc_q;
		for (int i = 0; i < LANE_BYTES; i++) begin
			p = 7'(i) - 7'(base_q) + {1'b0, pos_q};
			if (4'(i) >= base_q && 4'(i) < base_q + done_cnt)
				xres[8*i +: 8] = q_head.data[8*i +: 8] ^ ks_flat[8*p[5:0] +: 8];
		end
	end

	assign need_block = q_valid && (q_head.count != base_q) && !ready_q;
	assign do_xor = (st_q == ST_IDLE) && q_valid && out_free && !cfg_we
		&& (q_head.count == base_q || ready_q);
	assign q_pop = do_xor && (q_head.count == base_q || base_q + done_cnt == q_head.count);

	always_comb begin
		if (salsa_q) begin
			init_d[0] = SIGMA0; init_d[5] = SIGMA1; init_d[10] = SIGMA2; init_d[15] = SIGMA3;
			init_d[1] = key_q[0][31:0]; init_d[2] = key_q[0][63:32];
			init_d[3] = key_q[1][31:0]; init_d[4] = key_q[1][63:32];
			init_d[11] = key_q[2][31:0]; init_d[12] = key_q[2][63:32];
			init_d[13] = key_q[3][31:0]; init_d[14] = key_q[3][63:32];
			init_d[6] = nonce_lo_q[31:0]; init_d[7] = nonce_lo_q[63:32];
			init_d[8] = ctr_q[31:0]; init_d[9] = ctr_q[63:32];
		end else begin
			init_d[0] = SIGMA0; init_d[1] = SIGMA1; init_d[2] = SIGMA2; init_d[3] = SIGMA3;
			for (int i = 0; i < 4; i++) begin
				init_d[4 + 2*i] = key_q[i][31:0];
				init_d[5 + 2*i] = key_q[i][63:32];
			end
			init_d[12] = ctr_q[31:0];
			init_d[13] = nonce_lo_q[31:0];
			init_d[14] = nonce_lo_q[63:32];
			init_d[15] = nonce_hi_q;
		end
		dr = double_round(work_q, salsa_q);
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (need_block && !cfg_we) st_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 4'(DOUBLE_ROUNDS - 1)) st_d = ST_XOR;
			ST_XOR: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && need_block) begin
			init_q <= init_d;
			work_q <= init_d;
		end else if (st_q == ST_ROUND) begin
			work_q <= dr;
		end
		if (st_q == ST_XOR) begin
			for (int i = 0; i < 16; i++) ks_q[i] <= work_q[i] + init_q[i];
		end
		if (do_xor && q_pop) begin
			odata_q <= xres;
			ocnt_q <= q_head.count;
			olast_q <= q_head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salsa_q <= 1'b1;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce_lo_q <= '0;
			nonce_hi_q <= '0;
			start_q <= '0;
			ctr_q <= '0;
			pos_q <= '0;
			ready_q <= 1'b0;
			rnd_q <= '0;
			ovalid_q <= 1'b0;
			base_q <= '0;
			acc_q <= '0;
		end else begin
			if (out_free) ovalid_q <= 1'b0;
			if (st_q == ST_ROUND) rnd_q <= rnd_q + 1'b1;
			else rnd_q <= '0;
			if (st_q == ST_XOR) ready_q <= 1'b1;
			if (do_xor) begin
				acc_q <= q_pop ? '0 : xres;
				if (q_pop) begin
					ovalid_q <= 1'b1;
					base_q <= '0;
				end else begin
					base_q <= base_q + done_cnt;
				end
				if (q_head.count != base_q) begin
					pos_q <= new_pos;
					if (wrap) begin
						ready_q <= 1'b0;
						ctr_q <= ctr_q + 64'd1;
					end
				end
				if (q_pop && q_head.last) begin
					ctr_q <= start_q;
					pos_q <= '0;
					ready_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_CIPHER: salsa_q <= cfg_data[0];
					REG_KEY0: key_q[0] <= cfg_data;
					REG_KEY1: key_q[1] <= cfg_data;
					REG_KEY2: key_q[2] <= cfg_data;
					REG_KEY3: key_q[3] <= cfg_data;
					REG_NONCE_LO: nonce_lo_q <= cfg_data;
					REG_NONCE_HI: nonce_hi_q <= cfg_data[31:0];
					REG_START: begin
						start_q <= cfg_data;
						ctr_q <= cfg_data;
						pos_q <= '0;
					end
					default: ;
				endcase
				ready_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
